// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define DMDR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// cons must hold on the edge after ante
`define DMDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define DMDR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define DMDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/dmdr_pkg.sv =====
// ---------------------------------------------------------------------------
// dmdr_pkg
// Shared codes, constants and types of the dual motor duty ramp.
// ---------------------------------------------------------------------------
`default_nettype none

package dmdr_pkg;

    localparam int DUTY_WIDTH_DEF = 10;
    localparam int CFG_WIDTH      = 10;
    localparam int REQ_WIDTH      = 16;
    localparam int DIR_WIDTH      = 2;
    localparam int OP_WIDTH       = 3;
    localparam int VALVE_WIDTH    = 8;

    localparam int DUTY_CAP_RST   = 1000;
    localparam int RAMP_STEP_RST  = 10;

    // valve mapping
    localparam int VALVE_MAX      = 100;
    localparam int VALVE_HALF     = 50;
    localparam int VALVE_SCALE    = 10;
    localparam int VALVE_OFFSET   = 500;

    localparam logic [OP_WIDTH-1:0] OP_SET_DUTY = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_STOP_ONE = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_STOP_ALL = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_TICK     = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_VALVE    = 3'd4;

    localparam logic [DIR_WIDTH-1:0] DIR_STOP    = 2'd0;
    localparam logic [DIR_WIDTH-1:0] DIR_FORWARD = 2'd1;

    localparam logic [1:0] REG_DUTY_CAP  = 2'd0;
    localparam logic [1:0] REG_RAMP_STEP = 2'd1;

    localparam logic MOTOR_A = 1'b0;
    localparam logic MOTOR_B = 1'b1;

    // per-motor command for one beat; at most one flag set
    typedef struct packed {
        logic load;
        logic halt;
        logic tick;
    } t_motor_cmd;

endpackage

`default_nettype wire

// ===== sv/dmdr_motor.sv =====
// ---------------------------------------------------------------------------
// dmdr_motor
// State and update of one motor: load, halt and ramp step.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dmdr_motor #(
    parameter int DUTY_WIDTH = dmdr_pkg::DUTY_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire dmdr_pkg::t_motor_cmd        i_cmd,
    input  wire [dmdr_pkg::REQ_WIDTH-1:0]    i_duty,
    input  wire [dmdr_pkg::DIR_WIDTH-1:0]    i_dir,
    input  wire [DUTY_WIDTH-1:0]             i_duty_cap,
    input  wire [DUTY_WIDTH-1:0]             i_ramp_step,
    output logic [DUTY_WIDTH-1:0]            o_cur,
    output logic [DUTY_WIDTH-1:0]            o_tgt,
    output logic [dmdr_pkg::DIR_WIDTH-1:0]   o_dir,
    output logic                             o_pin,
    output logic                             o_run
);

    logic [DUTY_WIDTH-1:0]          r_cur, n_cur;
    logic [DUTY_WIDTH-1:0]          r_tgt, n_tgt;
    logic [dmdr_pkg::DIR_WIDTH-1:0] r_dir, n_dir;
    logic                           r_pin, n_pin;
    logic                           r_run, n_run;

    logic [DUTY_WIDTH-1:0] clamped;
    logic [DUTY_WIDTH:0]   sum_up;
    logic [DUTY_WIDTH-1:0] gap_dn;

    always_comb begin
        clamped = (i_duty > dmdr_pkg::REQ_WIDTH'(i_duty_cap)) ? i_duty_cap
                                                              : i_duty[DUTY_WIDTH-1:0];
        sum_up  = {1'b0, r_cur} + {1'b0, i_ramp_step};
        gap_dn  = r_cur - r_tgt;

        n_cur = r_cur;
        n_tgt = r_tgt;
        n_dir = r_dir;
        n_pin = r_pin;
        n_run = r_run;

        if (i_cmd.load) begin
            n_tgt = clamped;
            n_dir = i_dir;
            n_run = (clamped != '0) && (i_dir != dmdr_pkg::DIR_STOP);
            n_pin = (i_dir != dmdr_pkg::DIR_FORWARD);
        end else if (i_cmd.halt) begin
            // pin keeps its last level
            n_tgt = '0;
            n_cur = '0;
            n_run = 1'b0;
            n_dir = dmdr_pkg::DIR_STOP;
        end else if (i_cmd.tick) begin
            if (r_cur < r_tgt) begin
                n_cur = (sum_up > {1'b0, r_tgt}) ? r_tgt : sum_up[DUTY_WIDTH-1:0];
            end else if (r_cur > r_tgt) begin
                // land on target rather than wrap below it
                n_cur = (i_ramp_step > gap_dn) ? r_tgt : r_cur - i_ramp_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_tgt <= '0;
            r_dir <= dmdr_pkg::DIR_STOP;
            r_pin <= 1'b0;
            r_run <= 1'b0;
        end else if (i_en) begin
            r_cur <= n_cur;
            r_tgt <= n_tgt;
            r_dir <= n_dir;
            r_pin <= n_pin;
            r_run <= n_run;
        end
    end

    // status after this beat's update
    assign o_cur = n_cur;
    assign o_tgt = n_tgt;
    assign o_dir = n_dir;
    assign o_pin = n_pin;
    assign o_run = n_run;

    `DMDR_ASSERT_NEXT(a_halt_zero, i_clk, i_rst_n, i_en && i_cmd.halt, r_cur == '0 && r_tgt == '0)
    `DMDR_ASSERT_NEXT(a_no_overshoot, i_clk, i_rst_n, i_en && i_cmd.tick && r_cur <= r_tgt, r_cur <= r_tgt)
    `DMDR_ASSERT_ALWAYS(a_run_consistent, i_clk, i_rst_n, !r_run || (r_tgt != '0 && r_dir != dmdr_pkg::DIR_STOP))
    `DMDR_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !i_en, r_cur == $past(r_cur) && r_tgt == $past(r_tgt))

endmodule

`default_nettype wire

// ===== sv/dual_motor_duty_ramp_core.sv =====
// ---------------------------------------------------------------------------
// dual_motor_duty_ramp_core
// Two-motor PWM duty ramp: command decode, per-motor update, status stream.
// ---------------------------------------------------------------------------
//  channel     dir  handshake                     content
//  s_axis      in   s_axis_tvalid/s_axis_tready   one command beat
//  m_axis      out  m_axis_tvalid/m_axis_tready   full status after that command
//  cfg         in   i_cfg_valid/o_cfg_ready       duty cap (0), ramp_step (1)
//
//  One beat per cycle sustained while m_axis is not stalled; each command passes
//  the input register, then the motor update into the status register.
//  Synchronous active-low reset: both motors stopped at zero duty,
//  duty cap 1000, ramp_step 10. No clearing pass.
//  A stalled m_axis holds both registers; s_axis_tready drops only when the
//  input register is full and the status register cannot move on.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_motor_duty_ramp_core #(
    parameter int DUTY_WIDTH = dmdr_pkg::DUTY_WIDTH_DEF,
    localparam int OUT_BITS  = 4 * DUTY_WIDTH + 4 * dmdr_pkg::DIR_WIDTH,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // duty_request[15:0], direction_request[17:16], valve_position[25:18]
    input  wire [31:0]                       s_axis_tdata,
    // operation[2:0], motor_select[3]
    input  wire [7:0]                        s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // compare_a, compare_b, target_a, target_b (DUTY_WIDTH each),
    // direction_a, direction_b (2 each), dir_pin_a, dir_pin_b,
    // running_a, running_b, zero fill
    output logic [OUT_W-1:0]                 m_axis_tdata,

    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [1:0]                        i_cfg_index,
    input  wire [dmdr_pkg::CFG_WIDTH-1:0]    i_cfg_data
);

    localparam int RW = dmdr_pkg::REQ_WIDTH;
    localparam int DW = dmdr_pkg::DIR_WIDTH;

    // configuration
    logic [DUTY_WIDTH-1:0] r_duty_cap;
    logic [DUTY_WIDTH-1:0] r_ramp_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_cap  <= DUTY_WIDTH'(dmdr_pkg::DUTY_CAP_RST);
            r_ramp_step <= DUTY_WIDTH'(dmdr_pkg::RAMP_STEP_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dmdr_pkg::REG_DUTY_CAP:  r_duty_cap  <= DUTY_WIDTH'(i_cfg_data);
                dmdr_pkg::REG_RAMP_STEP: r_ramp_step <= DUTY_WIDTH'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // input register
    logic                              r_in_valid;
    logic [dmdr_pkg::OP_WIDTH-1:0]     r_op;
    logic                              r_sel;
    logic [RW-1:0]                     r_duty;
    logic [DW-1:0]                     r_dir;
    logic [dmdr_pkg::VALVE_WIDTH-1:0]  r_valve;
    logic                              advance;

    assign advance       = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op    <= s_axis_tuser[2:0];
            r_sel   <= s_axis_tuser[3];
            r_duty  <= s_axis_tdata[15:0];
            r_dir   <= s_axis_tdata[17:16];
            r_valve <= s_axis_tdata[25:18];
        end
    end

    // command decode
    logic [6:0]            valve_pct;
    logic [9:0]            valve_scaled;
    logic                  valve_open;
    dmdr_pkg::t_motor_cmd  cmd_a, cmd_b;
    logic [RW-1:0]         duty_a, duty_b;
    logic [DW-1:0]         dir_a, dir_b;

    always_comb begin
        valve_pct    = (r_valve > 8'(dmdr_pkg::VALVE_MAX)) ? 7'(dmdr_pkg::VALVE_MAX)
                                                           : r_valve[6:0];
        valve_scaled = 10'(valve_pct) * 10'(dmdr_pkg::VALVE_SCALE);
        valve_open   = valve_pct > 7'(dmdr_pkg::VALVE_HALF);

        cmd_a  = '0;
        cmd_b  = '0;
        duty_a = r_duty;
        duty_b = r_duty;
        dir_a  = r_dir;
        dir_b  = r_dir;

        case (r_op)
            dmdr_pkg::OP_SET_DUTY: begin
                cmd_a.load = (r_sel == dmdr_pkg::MOTOR_A);
                cmd_b.load = (r_sel == dmdr_pkg::MOTOR_B);
            end
            dmdr_pkg::OP_STOP_ONE: begin
                cmd_a.halt = (r_sel == dmdr_pkg::MOTOR_A);
                cmd_b.halt = (r_sel == dmdr_pkg::MOTOR_B);
            end
            dmdr_pkg::OP_STOP_ALL: begin
                cmd_a.halt = 1'b1;
                cmd_b.halt = 1'b1;
            end
            dmdr_pkg::OP_TICK: begin
                cmd_a.tick = 1'b1;
                cmd_b.tick = 1'b1;
            end
            dmdr_pkg::OP_VALVE: begin
                // opening drives A forward, closing drives B forward
                cmd_a.load = 1'b1;
                cmd_b.load = 1'b1;
                if (valve_open) begin
                    duty_a = RW'(valve_scaled - 10'(dmdr_pkg::VALVE_OFFSET));
                    dir_a  = dmdr_pkg::DIR_FORWARD;
                    duty_b = '0;
                    dir_b  = dmdr_pkg::DIR_STOP;
                end else begin
                    duty_b = RW'(10'(dmdr_pkg::VALVE_OFFSET) - valve_scaled);
                    dir_b  = dmdr_pkg::DIR_FORWARD;
                    duty_a = '0;
                    dir_a  = dmdr_pkg::DIR_STOP;
                end
            end
            default: ;
        endcase
    end

    logic [DUTY_WIDTH-1:0] cur_a, cur_b, tgt_a, tgt_b;
    logic [DW-1:0]         sdir_a, sdir_b;
    logic                  pin_a, pin_b, run_a, run_b;

    dmdr_motor #(.DUTY_WIDTH(DUTY_WIDTH)) u_motor_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_cmd       (cmd_a),
        .i_duty      (duty_a),
        .i_dir       (dir_a),
        .i_duty_cap  (r_duty_cap),
        .i_ramp_step (r_ramp_step),
        .o_cur       (cur_a),
        .o_tgt       (tgt_a),
        .o_dir       (sdir_a),
        .o_pin       (pin_a),
        .o_run       (run_a)
    );

    dmdr_motor #(.DUTY_WIDTH(DUTY_WIDTH)) u_motor_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_cmd       (cmd_b),
        .i_duty      (duty_b),
        .i_dir       (dir_b),
        .i_duty_cap  (r_duty_cap),
        .i_ramp_step (r_ramp_step),
        .o_cur       (cur_b),
        .o_tgt       (tgt_b),
        .o_dir       (sdir_b),
        .o_pin       (pin_b),
        .o_run       (run_b)
    );

    // status register
    logic [OUT_BITS-1:0] status;

    assign status = {run_b, run_a, pin_b, pin_a, sdir_b, sdir_a, tgt_b, tgt_a, cur_b, cur_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (advance) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            m_axis_tdata <= OUT_W'(status);
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_dual_motor_duty_ramp_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dual_motor_duty_ramp_core
// Self-checking bench for the two-motor duty ramp. Commands are driven on
// s_axis and each is run through a duty-ramp predictor. Every status beat on
// m_axis is checked field by field against the oldest predicted status.
// The limits are reprogrammed between phases, including both extremes.
// The phases cycle through four idling profiles on the two streams, and one
// phase holds the status side off long enough to back up the command input.
// ---------------------------------------------------------------------------
module tb_dual_motor_duty_ramp_core;

    localparam int DW             = 10;
    localparam int CW             = dmdr_pkg::CFG_WIDTH;
    localparam int STATUS_W       = 48;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 200;
    localparam int NUM_PHASES     = 8;

    localparam logic [dmdr_pkg::OP_WIDTH-1:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [dmdr_pkg::OP_WIDTH-1:0]  OP_SPARE_MID   = 3'd6;
    localparam logic [dmdr_pkg::OP_WIDTH-1:0]  OP_SPARE_LAST  = 3'd7;
    localparam logic [dmdr_pkg::DIR_WIDTH-1:0] DIR_REVERSE    = 2'd2;
    localparam logic [dmdr_pkg::DIR_WIDTH-1:0] DIR_ODD        = 2'd3;

    typedef struct packed {
        logic          running_b;
        logic          running_a;
        logic          pin_b;
        logic          pin_a;
        logic [1:0]    direction_b;
        logic [1:0]    direction_a;
        logic [DW-1:0] target_b;
        logic [DW-1:0] target_a;
        logic [DW-1:0] compare_b;
        logic [DW-1:0] compare_a;
    } t_motor_status;

    class duty_ramp_scoreboard;
        logic [DW-1:0]  duty_cap;
        logic [DW-1:0]  ramp_step;
        logic [DW-1:0]  target[2];
        logic [DW-1:0]  current[2];
        logic [1:0]     direction[2];
        logic           running[2];
        logic           pin[2];
        t_motor_status  status_q[$];
        int             failures;

        function new();
            duty_cap  = DW'(dmdr_pkg::DUTY_CAP_RST);
            ramp_step = DW'(dmdr_pkg::RAMP_STEP_RST);
            failures  = 0;
            for (int m = 0; m < 2; m++) begin
                target[m]    = '0;
                current[m]   = '0;
                direction[m] = dmdr_pkg::DIR_STOP;
                running[m]   = 1'b0;
                pin[m]       = 1'b0;
            end
        endfunction

        function void write_register(logic [1:0] idx, logic [CW-1:0] val);
            if (idx == dmdr_pkg::REG_DUTY_CAP)
                duty_cap = DW'(val);
            else if (idx == dmdr_pkg::REG_RAMP_STEP)
                ramp_step = DW'(val);
        endfunction

        function void load_target(int m, int unsigned duty, logic [1:0] dir);
            int unsigned d;
            d = (duty > duty_cap) ? duty_cap : duty;
            target[m]    = DW'(d);
            direction[m] = dir;
            running[m]   = (d != 0) && (dir != dmdr_pkg::DIR_STOP);
            pin[m]       = (dir == dmdr_pkg::DIR_FORWARD) ? 1'b0 : 1'b1;
        endfunction

        function void halt(int m);
            // direction pin deliberately left alone
            target[m]    = '0;
            current[m]   = '0;
            running[m]   = 1'b0;
            direction[m] = dmdr_pkg::DIR_STOP;
        endfunction

        function void step_toward_target(int m);
            int unsigned cur, tgt, nxt;
            cur = current[m];
            tgt = target[m];
            if (cur < tgt) begin
                nxt = cur + ramp_step;
                current[m] = DW'((nxt > tgt) ? tgt : nxt);
            end else if (cur > tgt) begin
                current[m] = DW'((ramp_step > cur - tgt) ? tgt : cur - ramp_step);
            end
        endfunction

        function void absorb_command(logic [2:0] op, logic sel, logic [15:0] duty,
                                     logic [1:0] dir, logic [7:0] pos);
            int unsigned   pct;
            t_motor_status st;
            case (op)
                dmdr_pkg::OP_SET_DUTY: load_target(sel, duty, dir);
                dmdr_pkg::OP_STOP_ONE: halt(sel);
                dmdr_pkg::OP_STOP_ALL: begin
                    halt(0);
                    halt(1);
                end
                dmdr_pkg::OP_TICK: begin
                    step_toward_target(0);
                    step_toward_target(1);
                end
                dmdr_pkg::OP_VALVE: begin
                    pct = (pos > dmdr_pkg::VALVE_MAX) ? dmdr_pkg::VALVE_MAX : pos;
                    if (pct > dmdr_pkg::VALVE_HALF) begin
                        load_target(0, pct * dmdr_pkg::VALVE_SCALE - dmdr_pkg::VALVE_OFFSET,
                                    dmdr_pkg::DIR_FORWARD);
                        load_target(1, 0, dmdr_pkg::DIR_STOP);
                    end else begin
                        load_target(1, dmdr_pkg::VALVE_OFFSET - pct * dmdr_pkg::VALVE_SCALE,
                                    dmdr_pkg::DIR_FORWARD);
                        load_target(0, 0, dmdr_pkg::DIR_STOP);
                    end
                end
                default: ;
            endcase
            st.compare_a   = current[0];
            st.compare_b   = current[1];
            st.target_a    = target[0];
            st.target_b    = target[1];
            st.direction_a = direction[0];
            st.direction_b = direction[1];
            st.pin_a       = pin[0];
            st.pin_b       = pin[1];
            st.running_a   = running[0];
            st.running_b   = running[1];
            status_q.push_back(st);
        endfunction

        function void check_field(string label, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
                failures++;
            end
        endfunction

        function void compare_status(logic [STATUS_W-1:0] raw);
            t_motor_status want, got;
            got = raw;
            if (status_q.size() == 0) begin
                $display("%0t: status beat with none expected, got %h", $time, raw);
                failures++;
                return;
            end
            want = status_q.pop_front();
            check_field("compare_a",   want.compare_a,   got.compare_a);
            check_field("compare_b",   want.compare_b,   got.compare_b);
            check_field("target_a",    want.target_a,    got.target_a);
            check_field("target_b",    want.target_b,    got.target_b);
            check_field("direction_a", want.direction_a, got.direction_a);
            check_field("direction_b", want.direction_b, got.direction_b);
            check_field("dir_pin_a",   want.pin_a,       got.pin_a);
            check_field("dir_pin_b",   want.pin_b,       got.pin_b);
            check_field("running_a",   want.running_a,   got.running_a);
            check_field("running_b",   want.running_b,   got.running_b);
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [31:0]             s_axis_tdata  = '0;
    logic [7:0]              s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [STATUS_W-1:0]     m_axis_tdata;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index   = '0;
    logic [CW-1:0]           i_cfg_data    = '0;

    duty_ramp_scoreboard     sb;
    int unsigned             send_idle_pct = 0;
    int unsigned             stall_pct     = 0;
    bit                      hold_request  = 1'b0;
    int                      hold_left     = 0;
    int                      quiet_cycles  = 0;

    dual_motor_duty_ramp_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // status sink: random stalls, plus the long hold-off when asked for
    always @(posedge i_clk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // beat monitor and watchdog
    always @(posedge i_clk) begin : monitor
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_register(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.absorb_command(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata[15:0],
                                  s_axis_tdata[17:16], s_axis_tdata[25:18]);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.compare_status(m_axis_tdata);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("dual_motor_duty_ramp_core: mismatch");
                $finish;
            end
        end
    end

    // leaves tvalid high so back-to-back beats follow without a gap
    task automatic send_command(input logic [2:0] op, input logic sel,
                                input logic [15:0] duty, input logic [1:0] dir,
                                input logic [7:0] pos);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {4'b0, sel, op};
        s_axis_tdata  <= {6'b0, pos, dir, duty};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic program_limits(input logic [CW-1:0] cap,
                                  input logic [CW-1:0] step);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= dmdr_pkg::REG_DUTY_CAP;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= dmdr_pkg::REG_RAMP_STEP;
        i_cfg_data  <= step;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for a clock edge first so the last accepted beat is already on the queue
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        int unsigned   pick;
        logic [2:0]    op;
        logic [15:0]   duty;
        logic [1:0]    dir;
        logic [7:0]    pos;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35)      op = dmdr_pkg::OP_SET_DUTY;
            else if (pick < 75) op = dmdr_pkg::OP_TICK;
            else if (pick < 85) op = dmdr_pkg::OP_VALVE;
            else if (pick < 91) op = dmdr_pkg::OP_STOP_ONE;
            else if (pick < 94) op = dmdr_pkg::OP_STOP_ALL;
            else                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            pick = $urandom_range(99);
            if (pick < 75) duty = 16'($urandom_range(0, 1023));
            else           duty = 16'($urandom());
            dir = ($urandom_range(99) < 10) ? DIR_ODD : 2'($urandom_range(0, 2));
            pos = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 110))
                                            : 8'($urandom_range(0, 255));
            send_command(op, 1'($urandom_range(0, 1)), duty, dir, pos);
        end
    endtask

    initial begin
        int unsigned phase_max[NUM_PHASES];
        int unsigned phase_step[NUM_PHASES];
        int unsigned send_prof[4];
        int unsigned stall_prof[4];

        phase_max  = '{1000, 1023, 0, 1023, 300, 512, 1023, 777};
        phase_step = '{10, 1023, 1, 0, 1, 37, 3, 200};
        send_prof  = '{0, 71, 0, 31};
        stall_prof = '{0, 0, 71, 31};

        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening, reset limits, no idling
        send_command(dmdr_pkg::OP_SET_DUTY, dmdr_pkg::MOTOR_A, 16'hFFFF, dmdr_pkg::DIR_FORWARD,
                     8'd0);
        send_command(dmdr_pkg::OP_SET_DUTY, dmdr_pkg::MOTOR_B, 16'd0, DIR_REVERSE, 8'd0);
        send_command(dmdr_pkg::OP_TICK, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_SET_DUTY, dmdr_pkg::MOTOR_B, 16'd700, DIR_ODD, 8'hFF);
        send_command(dmdr_pkg::OP_TICK, dmdr_pkg::MOTOR_B, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_TICK, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_SET_DUTY, dmdr_pkg::MOTOR_A, 16'd5, dmdr_pkg::DIR_STOP, 8'd0);
        // current above target by more than one step
        send_command(dmdr_pkg::OP_TICK, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_TICK, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_STOP_ONE, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_STOP_ONE, dmdr_pkg::MOTOR_B, 16'hFFFF, DIR_ODD, 8'hFF);
        send_command(dmdr_pkg::OP_SET_DUTY, dmdr_pkg::MOTOR_A, 16'd1000, dmdr_pkg::DIR_FORWARD,
                     8'd0);
        send_command(dmdr_pkg::OP_SET_DUTY, dmdr_pkg::MOTOR_B, 16'd1001, dmdr_pkg::DIR_FORWARD,
                     8'd0);
        send_command(dmdr_pkg::OP_TICK, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_STOP_ALL, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_VALVE, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        send_command(dmdr_pkg::OP_VALVE, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd50);
        send_command(dmdr_pkg::OP_VALVE, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd51);
        send_command(dmdr_pkg::OP_VALVE, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd100);
        send_command(dmdr_pkg::OP_VALVE, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd101);
        send_command(dmdr_pkg::OP_VALVE, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd255);
        send_command(OP_SPARE_FIRST, dmdr_pkg::MOTOR_B, 16'hFFFF, DIR_ODD, 8'hFF);
        send_command(OP_SPARE_MID, dmdr_pkg::MOTOR_A, 16'd123, dmdr_pkg::DIR_FORWARD, 8'd7);
        send_command(OP_SPARE_LAST, dmdr_pkg::MOTOR_B, 16'd9, DIR_REVERSE, 8'd60);
        send_command(dmdr_pkg::OP_TICK, dmdr_pkg::MOTOR_A, 16'd0, dmdr_pkg::DIR_STOP, 8'd0);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1)
                program_limits(CW'($urandom_range(0, 1023)), CW'($urandom_range(1, 1023)));
            else
                program_limits(CW'(phase_max[p]), CW'(phase_step[p]));
            send_idle_pct = send_prof[p % 4];
            stall_pct     = stall_prof[p % 4];
            // back-pressure: sink stops while commands keep coming
            if (p == 4)
                hold_request = 1'b1;
            run_random(PHASE_ITEMS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("dual_motor_duty_ramp_core: match");
        else
            $display("dual_motor_duty_ramp_core: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dmdr_pkg.sv
sv/dmdr_motor.sv
sv/dual_motor_duty_ramp_core.sv
tb/tb_dual_motor_duty_ramp_core.sv
